FILE: sv/abpt_pkg.sv
// Package: shared constants, types and tables for the arc bend point transform.
package abpt_pkg;

	localparam int COORD_WIDTH_DEF = 32;
	localparam int FRAC_BITS       = 16;
	localparam int CFG_WIDTH       = 31;
	localparam int RAD_WIDTH       = 31;
	localparam int ANG_BITS        = 30;
	localparam int ITERS           = 30;
	localparam int ITER_W          = 5;
	localparam int CFG_IDX_W       = 2;

	// Angle word: Q30 radians with headroom for +-2pi.
	localparam int ANG_W  = 36;
	localparam int CORD_W = 34;

	localparam logic [CFG_IDX_W-1:0] REG_CURVATURE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DOMAIN    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STRAIGHT  = 2'd2;

	localparam logic signed [ANG_W-1:0] PI_Q30      = 36'sd3373259426;
	localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 36'sd1686629713;
	localparam logic signed [ANG_W-1:0] TWO_PI_Q30  = 36'sd6746518852;
	localparam logic signed [CORD_W-1:0] GAIN_Q30   = 34'sd652032874;

	function automatic logic signed [ANG_W-1:0] atan_q30(input logic [ITER_W-1:0] i);
		logic signed [ANG_W-1:0] v;
		v = '0;
		case (i)
			5'd0:  v = 36'sd843314856;
			5'd1:  v = 36'sd497837829;
			5'd2:  v = 36'sd263043836;
			5'd3:  v = 36'sd133525158;
			5'd4:  v = 36'sd67021686;
			5'd5:  v = 36'sd33543515;
			5'd6:  v = 36'sd16775850;
			5'd7:  v = 36'sd8388437;
			5'd8:  v = 36'sd4194282;
			5'd9:  v = 36'sd2097149;
			5'd10: v = 36'sd1048575;
			5'd11: v = 36'sd524287;
			5'd12: v = 36'sd262143;
			5'd13: v = 36'sd131071;
			5'd14: v = 36'sd65535;
			5'd15: v = 36'sd32767;
			5'd16: v = 36'sd16383;
			5'd17: v = 36'sd8191;
			5'd18: v = 36'sd4095;
			5'd19: v = 36'sd2047;
			5'd20: v = 36'sd1023;
			5'd21: v = 36'sd511;
			5'd22: v = 36'sd255;
			5'd23: v = 36'sd127;
			5'd24: v = 36'sd63;
			5'd25: v = 36'sd31;
			5'd26: v = 36'sd15;
			5'd27: v = 36'sd8;
			5'd28: v = 36'sd4;
			5'd29: v = 36'sd2;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

FILE: sv/abpt_div.sv
// Pipelined restoring divider: one quotient bit per stage, side data carried along.
module abpt_div #(
	parameter int NUM_W  = 61,
	parameter int DEN_W  = 31,
	parameter int SIDE_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [NUM_W-1:0]  num,
	input  logic [DEN_W-1:0]  den,
	input  logic [SIDE_W-1:0] side_in,
	output logic              out_valid,
	output logic [NUM_W-1:0]  quo,
	output logic [SIDE_W-1:0] side_out
);
	logic [NUM_W:0]      vld_s;
	logic [NUM_W-1:0]    n_s   [NUM_W+1];
	logic [DEN_W:0]      rem_s [NUM_W+1];
	logic [DEN_W-1:0]    d_s   [NUM_W+1];
	logic [SIDE_W-1:0]   sd_s  [NUM_W+1];

	assign vld_s[0] = in_valid;
	assign n_s[0]   = num;
	assign rem_s[0] = '0;
	assign d_s[0]   = den;
	assign sd_s[0]  = side_in;

	for (genvar k = 0; k < NUM_W; k++) begin : g_st
		logic [DEN_W+1:0] tr;
		logic [DEN_W+1:0] df;
		assign tr = {rem_s[k], n_s[k][NUM_W-1]};
		assign df = tr - {2'b00, d_s[k]};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				d_s[k+1]  <= d_s[k];
				sd_s[k+1] <= sd_s[k];
				if (!df[DEN_W+1]) begin
					rem_s[k+1] <= df[DEN_W:0];
					n_s[k+1]   <= {n_s[k][NUM_W-2:0], 1'b1};
				end else begin
					rem_s[k+1] <= tr[DEN_W:0];
					n_s[k+1]   <= {n_s[k][NUM_W-2:0], 1'b0};
				end
			end
		end
	end

	assign out_valid = vld_s[NUM_W];
	assign quo       = n_s[NUM_W];
	assign side_out  = sd_s[NUM_W];
endmodule

FILE: sv/abpt_cordic.sv
// Pipelined rotation-mode CORDIC with range folding, one iteration per stage.
module abpt_cordic #(
	parameter int SIDE_W = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                in_valid,
	input  logic signed [abpt_pkg::ANG_W-1:0]   ang,
	input  logic [SIDE_W-1:0]                   side_in,
	output logic                                out_valid,
	output logic signed [abpt_pkg::CORD_W-1:0]  sin_o,
	output logic signed [abpt_pkg::CORD_W-1:0]  cos_o,
	output logic [SIDE_W-1:0]                   side_out
);
	localparam int N  = abpt_pkg::ITERS;
	localparam int AW = abpt_pkg::ANG_W;
	localparam int CW = abpt_pkg::CORD_W;
	localparam int IW = abpt_pkg::ITER_W;
	localparam logic signed [AW-1:0] TWO_PI = abpt_pkg::TWO_PI_Q30;

	// fold stage: ang lies within (-2pi, 2pi)
	logic signed [AW-1:0] m0, m1, f;
	logic                 ng;
	logic                 v_f_s1;
	logic signed [AW-1:0] z_f_s1;
	logic                 ng_s1;
	logic [SIDE_W-1:0]    sd_f_s1;

	always_comb begin
		m0 = ang;
		if (m0 < 0) m0 = m0 + TWO_PI;
		m1 = m0;
		if (m1 > abpt_pkg::PI_Q30) m1 = m1 - TWO_PI;
		f  = m1;
		ng = 1'b0;
		if (m1 > abpt_pkg::HALF_PI_Q30) begin
			f  = abpt_pkg::PI_Q30 - m1;
			ng = 1'b1;
		end else if (m1 < -abpt_pkg::HALF_PI_Q30) begin
			f  = -abpt_pkg::PI_Q30 - m1;
			ng = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_f_s1 <= 1'b0;
		end else if (en) begin
			v_f_s1 <= in_valid;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			z_f_s1  <= f;
			ng_s1   <= ng;
			sd_f_s1 <= side_in;
		end
	end

	logic [N:0]           vld;
	logic signed [CW-1:0] xs [N+1];
	logic signed [CW-1:0] ys [N+1];
	logic signed [AW-1:0] zs [N+1];
	logic [N:0]           ngs;
	logic [SIDE_W-1:0]    sds [N+1];

	assign vld[0] = v_f_s1;
	assign xs[0]  = abpt_pkg::GAIN_Q30;
	assign ys[0]  = '0;
	assign zs[0]  = z_f_s1;
	assign ngs[0] = ng_s1;
	assign sds[0] = sd_f_s1;

	for (genvar i = 0; i < N; i++) begin : g_it
		localparam logic [IW-1:0] IDX = IW'(i);
		logic signed [CW-1:0] xsh, ysh;
		assign xsh = xs[i] >>> i;
		assign ysh = ys[i] >>> i;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld[i+1] <= 1'b0;
			end else if (en) begin
				vld[i+1] <= vld[i];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				ngs[i+1] <= ngs[i];
				sds[i+1] <= sds[i];
				if (zs[i] >= 0) begin
					xs[i+1] <= xs[i] - ysh;
					ys[i+1] <= ys[i] + xsh;
					zs[i+1] <= zs[i] - abpt_pkg::atan_q30(IDX);
				end else begin
					xs[i+1] <= xs[i] + ysh;
					ys[i+1] <= ys[i] - xsh;
					zs[i+1] <= zs[i] + abpt_pkg::atan_q30(IDX);
				end
			end
		end
	end

	assign out_valid = vld[N];
	assign sin_o     = ys[N];
	assign cos_o     = ngs[N] ? -xs[N] : xs[N];
	assign side_out  = sds[N];
endmodule

FILE: sv/arc_bend_point_transform.sv
// Top level: arc bend point transform pipeline.
// Usage:
//   Write the bend radius (0), domain_length (1) and straight_length (2) through
//   cfg_we/cfg_index/cfg_data while no word is in flight. Points enter on
//   in_valid/in_ready as one word of x_in, y_in, radius_in; results leave in
//   order on out_valid/out_ready. One word is accepted per cycle while in_ready is high.
//   The pipeline has 1 stage for center selection, 63 angle divider stages,
//   31 stages reducing the angle modulo 2pi, 1 sign stage, 1 fold stage plus
//   30 CORDIC stages, 2 multiply stages, 65 radius divider stages and the
//   output register; the two dividers hold most of them.
//   The pipeline advances as a whole; while a word waits at the output with
//   out_ready low, every stage holds and in_ready drops, so nothing is lost
//   or repeated. An output register holds the finished word meanwhile.
//   Reset clears all valid bits and the three registers to zero. With a zero
//   radius register points pass through unchanged with bent low.
//   Saturation applies to all three outputs.
//   Points between the centers pass through unchanged.
module arc_bend_point_transform #(
	parameter int COORD_WIDTH = abpt_pkg::COORD_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [abpt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [abpt_pkg::CFG_WIDTH-1:0]      cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [COORD_WIDTH-1:0]       x_in,
	input  logic signed [COORD_WIDTH-1:0]       y_in,
	input  logic [abpt_pkg::RAD_WIDTH-1:0]      radius_in,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [COORD_WIDTH-1:0]       x_out,
	output logic signed [COORD_WIDTH-1:0]       y_out,
	output logic [abpt_pkg::RAD_WIDTH-1:0]      radius_out,
	output logic                                bent
);
	localparam int CW  = COORD_WIDTH;
	localparam int RW  = abpt_pkg::RAD_WIDTH;
	localparam int AB  = abpt_pkg::ANG_BITS;
	localparam int AW  = abpt_pkg::ANG_W;
	localparam int WW  = CW + 2;
	localparam int NUM_W = WW + AB - 1;
	localparam int PW  = WW + abpt_pkg::CORD_W;
	localparam int RPW = RW + WW;
	// side data: x, y, rad, cx, neg, bent
	localparam int SIDE_W = CW + CW + RW + WW + 2;
	// 2pi exceeds 2^32, so this many halvings cover the whole quotient
	localparam int RED_N = NUM_W - 32;
	localparam logic [NUM_W-1:0] TWO_PI_W = NUM_W'(abpt_pkg::TWO_PI_Q30);

	logic [abpt_pkg::CFG_WIDTH-1:0] r_q, len_q, str_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_q <= '0; len_q <= '0; str_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				abpt_pkg::REG_CURVATURE: r_q   <= cfg_data;
				abpt_pkg::REG_DOMAIN:    len_q <= cfg_data;
				abpt_pkg::REG_STRAIGHT:  str_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic en;
	logic out_v_q;
	assign en = !out_v_q || out_ready;
	assign in_ready = en;

	// stage 1: centres and distance
	logic signed [WW-1:0] lo, hi, xw, cx, dd;
	logic                 bnd;
	always_comb begin
		lo  = WW'(($signed({2'b00, len_q}) - $signed({2'b00, str_q})) >>> 1);
		hi  = WW'(($signed({2'b00, len_q}) + $signed({2'b00, str_q})) >>> 1);
		xw  = WW'(x_in);
		bnd = (r_q != '0) && (xw < lo || xw > hi);
		cx  = (xw < lo) ? lo : hi;
		dd  = xw - cx;
	end

	logic                 v_s1, bnd_s1, neg_s1;
	logic signed [CW-1:0] x_s1, y_s1;
	logic [RW-1:0]        rad_s1;
	logic signed [WW-1:0] cx_s1;
	logic [WW-1:0]        mag_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= x_in; y_s1 <= y_in; rad_s1 <= radius_in;
			bnd_s1 <= bnd; cx_s1 <= cx; neg_s1 <= dd[WW-1];
			mag_s1 <= dd[WW-1] ? WW'(-dd) : WW'(dd);
		end
	end

	// angle divider
	logic               dv_v;
	logic [NUM_W-1:0]   dv_q;
	logic [SIDE_W-1:0]  dv_sd;
	abpt_div #(.NUM_W(NUM_W), .DEN_W(RW), .SIDE_W(SIDE_W)) u_adiv (
		.clk, .arst_n, .en, .in_valid(v_s1),
		.num({mag_s1[WW-2:0], {AB{1'b0}}}), .den(r_q),
		.side_in({x_s1, y_s1, rad_s1, cx_s1, neg_s1, bnd_s1}),
		.out_valid(dv_v), .quo(dv_q), .side_out(dv_sd)
	);

	// reduce quotient modulo 2pi: one compare and subtract of a shifted 2pi per stage
	logic [RED_N:0]    rd_v;
	logic [NUM_W-1:0]  rd_m  [RED_N+1];
	logic [SIDE_W-1:0] rd_sd [RED_N+1];
	assign rd_v[0]  = dv_v;
	assign rd_m[0]  = dv_q;
	assign rd_sd[0] = dv_sd;
	for (genvar k = 0; k < RED_N; k++) begin : g_red
		localparam logic [NUM_W-1:0] STEP = TWO_PI_W << (RED_N - 1 - k);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rd_v[k+1] <= 1'b0;
			end else if (en) begin
				rd_v[k+1] <= rd_v[k];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rd_sd[k+1] <= rd_sd[k];
				rd_m[k+1]  <= (rd_m[k] >= STEP) ? rd_m[k] - STEP : rd_m[k];
			end
		end
	end

	logic signed [AW-1:0] ang_s2;
	logic                 v_s2;
	logic [SIDE_W-1:0]    sd_s2;
	logic [NUM_W-1:0]     qm;
	assign qm = rd_m[RED_N];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= rd_v[RED_N];
	end
	always_ff @(posedge clk) begin
		if (en) begin
			sd_s2  <= rd_sd[RED_N];
			ang_s2 <= rd_sd[RED_N][1] ? -$signed(AW'(qm)) : $signed(AW'(qm));
		end
	end

	logic                               cv;
	logic signed [abpt_pkg::CORD_W-1:0] sn, cs;
	logic [SIDE_W-1:0]                  csd;
	abpt_cordic #(.SIDE_W(SIDE_W)) u_cordic (
		.clk, .arst_n, .en, .in_valid(v_s2), .ang(ang_s2), .side_in(sd_s2),
		.out_valid(cv), .sin_o(sn), .cos_o(cs), .side_out(csd)
	);

	// products
	logic signed [CW-1:0] cx_x, cx_y;
	logic [RW-1:0]        cx_rad;
	logic signed [WW-1:0] cx_c;
	logic                 cx_b;
	assign {cx_x, cx_y, cx_rad, cx_c} = csd[SIDE_W-1:2];
	assign cx_b = csd[0];

	logic                 v_s3, b_s3;
	logic signed [PW-1:0] px_s3, py_s3;
	logic signed [WW-1:0] rho_s3, cx_s3;
	logic signed [CW-1:0] x_s3, y_s3;
	logic [RW-1:0]        rad_s3;
	logic signed [WW-1:0] rho;
	assign rho = WW'(cx_y) + $signed({2'b00, r_q});
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= cv;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			px_s3 <= PW'(rho * sn); py_s3 <= PW'(rho * cs);
			rho_s3 <= rho; cx_s3 <= cx_c; b_s3 <= cx_b;
			x_s3 <= cx_x; y_s3 <= cx_y; rad_s3 <= cx_rad;
		end
	end

	function automatic logic signed [CW-1:0] sat(input logic signed [PW-1:0] v);
		logic signed [PW-1:0] mx, mn;
		mx = PW'({1'b0, {(CW-1){1'b1}}});
		mn = -mx - PW'(1);
		if (v > mx) return {1'b0, {(CW-1){1'b1}}};
		if (v < mn) return {1'b1, {(CW-1){1'b0}}};
		return CW'(v);
	endfunction

	logic signed [PW-1:0] rx, ry;
	assign rx = ((px_s3 + (PW'(1) <<< (AB-1))) >>> AB) + PW'(cx_s3);
	assign ry = ((py_s3 + (PW'(1) <<< (AB-1))) >>> AB) - $signed(PW'({2'b00, r_q}));

	logic                 v_s4, b_s4, rz_s4;
	logic signed [CW-1:0] xo_s4, yo_s4;
	logic [RW-1:0]        rad_s4;
	logic [RPW-1:0]       rp_s4;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en) v_s4 <= v_s3;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			b_s4 <= b_s3; rad_s4 <= rad_s3;
			xo_s4 <= b_s3 ? sat(rx) : x_s3;
			yo_s4 <= b_s3 ? sat(ry) : y_s3;
			rz_s4 <= rho_s3 <= 0;
			rp_s4 <= RPW'(rad_s3) * RPW'(rho_s3[WW-2:0]);
		end
	end

	logic                 rv;
	logic [RPW-1:0]       rq;
	logic [2*CW+RW+2-1:0] rsd;
	abpt_div #(.NUM_W(RPW), .DEN_W(RW), .SIDE_W(2*CW+RW+2)) u_rdiv (
		.clk, .arst_n, .en, .in_valid(v_s4), .num(rp_s4), .den(r_q),
		.side_in({xo_s4, yo_s4, rad_s4, rz_s4, b_s4}),
		.out_valid(rv), .quo(rq), .side_out(rsd)
	);

	logic signed [CW-1:0] fx, fy;
	logic [RW-1:0]        frad, rsel;
	logic                 frz, fb;
	assign {fx, fy, frad, frz, fb} = rsd;
	always_comb begin
		if (!fb) rsel = frad;
		else if (frz) rsel = '0;
		else if (rq > RPW'({RW{1'b1}})) rsel = '1;
		else rsel = RW'(rq);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_v_q <= 1'b0;
		else if (en) out_v_q <= rv;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			x_out <= fx; y_out <= fy; radius_out <= rsel; bent <= fb;
		end
	end
	assign out_valid = out_v_q;
endmodule

FILE: sv/abpt_checker.sv
// Port checker for the arc bend point transform, bound to the top level.
module abpt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [30:0] radius_out,
	input logic        bent
);
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready) else $error("ready while stalled");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(radius_out))
		else $error("output dropped");
	a_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready) else $error("stall without word");
	a_bent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(bent)) else $error("bent changed");
endmodule

bind arc_bend_point_transform abpt_checker u_chk (
	.clk, .arst_n, .in_ready, .out_valid, .out_ready, .radius_out, .bent
);

FILE: tb/arc_bend_point_transform_tb.sv
// Testbench for arc_bend_point_transform: directed and random points checked against a local predictor.
`timescale 1ns / 100ps

module arc_bend_point_transform_tb;

	localparam longint PI_Q       = 64'sd3373259426;
	localparam longint HALF_PI_Q  = 64'sd1686629713;
	localparam longint TWO_PI_Q   = 64'sd6746518852;
	localparam longint GAIN_Q     = 64'sd652032874;
	localparam longint CYCLE_LIMIT = 64'sd3000000;
	localparam int     DRAIN_CYCLES = 200;
	localparam logic [abpt_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	localparam longint ARCTAN [abpt_pkg::ITERS] = '{
		843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
		16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
		65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127, 63, 31,
		15, 8, 4, 2
	};

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic [30:0]        radius;
		logic               bent;
	} bent_point_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [abpt_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [abpt_pkg::CFG_WIDTH-1:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic signed [31:0] x_in;
	logic signed [31:0] y_in;
	logic [30:0] radius_in;
	logic        out_valid;
	logic        out_ready;
	logic signed [31:0] x_out;
	logic signed [31:0] y_out;
	logic [30:0] radius_out;
	logic        bent;

	logic [30:0] bend_r;
	logic [30:0] vessel_len;
	logic [30:0] straight_len;

	bent_point_t expected_points[$];
	int          errors;
	int          points_sent;
	int          points_bent;
	int          points_checked;
	longint      cycles;
	bit          no_idle;

	arc_bend_point_transform uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.x_in(x_in), .y_in(y_in), .radius_in(radius_in),
		.out_valid(out_valid), .out_ready(out_ready),
		.x_out(x_out), .y_out(y_out), .radius_out(radius_out), .bent(bent)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	function automatic longint sat32(input longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	function automatic void cordic_sin_cos(input longint ang, output longint s, output longint c);
		longint cx, cy, z, nx;
		bit     flip;
		cx = GAIN_Q;
		cy = 0;
		flip = 0;
		z = ang % TWO_PI_Q;
		if (z < 0)
			z += TWO_PI_Q;
		if (z > PI_Q)
			z -= TWO_PI_Q;
		if (z > HALF_PI_Q) begin
			z = PI_Q - z;
			flip = 1;
		end else if (z < -HALF_PI_Q) begin
			z = -PI_Q - z;
			flip = 1;
		end
		for (int i = 0; i < abpt_pkg::ITERS; i++) begin
			if (z >= 0) begin
				nx = cx - (cy >>> i);
				cy = cy + (cx >>> i);
				z -= ARCTAN[i];
			end else begin
				nx = cx + (cy >>> i);
				cy = cy - (cx >>> i);
				z += ARCTAN[i];
			end
			cx = nx;
		end
		s = cy;
		c = flip ? -cx : cx;
	endfunction

	function automatic bent_point_t wrap_point(input logic signed [31:0] px,
			input logic signed [31:0] py, input logic [30:0] prad);
		bent_point_t       res;
		longint            xs, ys, r, lo, hi, cx, d, phi, sn, cs, rho;
		longint unsigned   mag, q;
		xs = px;
		ys = py;
		r = longint'(bend_r);
		lo = (longint'(vessel_len) - longint'(straight_len)) >>> 1;
		hi = (longint'(vessel_len) + longint'(straight_len)) >>> 1;
		res.x = px;
		res.y = py;
		res.radius = prad;
		res.bent = 1'b0;
		if (r != 0 && (xs < lo || xs > hi)) begin
			res.bent = 1'b1;
			cx = (xs < lo) ? lo : hi;
			d = xs - cx;
			mag = (d < 0) ? -d : d;
			q = (mag << abpt_pkg::ANG_BITS) / longint'(r);
			phi = (d < 0) ? -longint'(q) : longint'(q);
			cordic_sin_cos(phi, sn, cs);
			rho = ys + r;
			res.x = 32'(sat32(((rho * sn + (64'sd1 <<< 29)) >>> abpt_pkg::ANG_BITS) + cx));
			res.y = 32'(sat32(((rho * cs + (64'sd1 <<< 29)) >>> abpt_pkg::ANG_BITS) - r));
			if (rho <= 0) begin
				res.radius = '0;
			end else begin
				q = (longint'(prad) * rho) / longint'(r);
				res.radius = (q > 64'h7fffffff) ? 31'h7fffffff : q[30:0];
			end
		end
		return res;
	endfunction

	function automatic int idle_len();
		int p;
		if (no_idle)
			return 0;
		p = $urandom_range(0, 99);
		if (p < 60)
			return 0;
		if (p < 94)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	task automatic send_point(input logic signed [31:0] px, input logic signed [31:0] py,
			input logic [30:0] prad);
		int gap;
		@(negedge clk);
		in_valid <= 1'b1;
		x_in <= px;
		y_in <= py;
		radius_in <= prad;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		expected_points.insert(expected_points.size(), wrap_point(px, py, prad));
		points_sent++;
		gap = idle_len();
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1)
				@(negedge clk);
		end
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_points.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [abpt_pkg::CFG_IDX_W-1:0] idx, input logic [30:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			abpt_pkg::REG_CURVATURE: bend_r = val;
			abpt_pkg::REG_DOMAIN:    vessel_len = val;
			abpt_pkg::REG_STRAIGHT:  straight_len = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_geometry(input logic [30:0] r, input logic [30:0] len,
			input logic [30:0] str);
		wait_drained();
		write_reg(abpt_pkg::REG_CURVATURE, r);
		write_reg(abpt_pkg::REG_DOMAIN, len);
		write_reg(abpt_pkg::REG_STRAIGHT, str);
	endtask

	// out_ready: random stalls, mostly short
	always @(negedge clk) begin
		int p;
		if (!arst_n || no_idle) begin
			out_ready <= 1'b1;
		end else begin
			p = $urandom_range(0, 99);
			if (p < 65)
				out_ready <= 1'b1;
			else if (p < 97)
				out_ready <= 1'b0;
			else begin
				out_ready <= 1'b0;
				repeat ($urandom_range(10, 50))
					@(negedge clk);
			end
		end
	end

	always @(posedge clk) begin
		bent_point_t exp_pt;
		if (arst_n && out_valid && out_ready) begin
			if (expected_points.size() == 0) begin
				$display("%0t: unexpected word x=%0d y=%0d r=%0d bent=%0b", $time,
					x_out, y_out, radius_out, bent);
				errors++;
			end else begin
				exp_pt = expected_points.pop_front();
				points_checked++;
				if (exp_pt.bent)
					points_bent++;
				if (x_out !== exp_pt.x) begin
					$display("%0t: x_out expected %0d actual %0d", $time, exp_pt.x, x_out);
					errors++;
				end
				if (y_out !== exp_pt.y) begin
					$display("%0t: y_out expected %0d actual %0d", $time, exp_pt.y, y_out);
					errors++;
				end
				if (radius_out !== exp_pt.radius) begin
					$display("%0t: radius_out expected %0d actual %0d", $time,
						exp_pt.radius, radius_out);
					errors++;
				end
				if (bent !== exp_pt.bent) begin
					$display("%0t: bent expected %0b actual %0b", $time, exp_pt.bent, bent);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d words outstanding", $time, expected_points.size());
			$display("[arc_bend_point_transform] ERROR");
			$finish;
		end
	end

	task automatic test_no_bend_after_reset();
		send_point(32'sh7fffffff, 32'sh80000000, 31'h7fffffff);
		send_point(32'sh80000000, 32'sh7fffffff, 31'h0);
		send_point(32'sh0, 32'sh0, 31'h10000);
		send_point(-32'sd65536, 32'sd12345, 31'h5555);
	endtask

	task automatic test_directed_geometry();
		// R = 10, length 100, straight 40: centers at 30 and 70
		set_geometry(31'd655360, 31'd6553600, 31'd2621440);
		send_point(32'sd3276800, 32'sd65536, 31'h10000);
		send_point(32'sd1966080, 32'sd65536, 31'h10000);
		send_point(32'sd4587520, 32'sd65536, 31'h10000);
		send_point(32'sd1966079, 32'sd0, 31'h10000);
		send_point(32'sd4587521, 32'sd0, 31'h10000);
		send_point(32'sd0, 32'sd131072, 31'h20000);
		send_point(32'sd6553600, -32'sd131072, 31'h20000);
		send_point(32'sd0, -32'sd655360, 31'h20000);
		send_point(32'sd0, -32'sd1000000, 31'h20000);
		send_point(32'sd1000000, 32'sh7fffffff, 31'h7fffffff);
		send_point(32'sh80000000, 32'sh80000000, 31'h7fffffff);
		send_point(32'sh7fffffff, 32'sh7fffffff, 31'h7fffffff);
		send_point(32'sd1500000, 32'sd300000, 31'h0);
		send_point(32'sd6000000, 32'sd20000000, 31'h7fffffff);
	endtask

	task automatic test_unused_index();
		wait_drained();
		write_reg(REG_UNUSED, 31'h1234567);
		send_point(32'sd100, 32'sd200, 31'h300);
		send_point(32'sd7000000, 32'sd200, 31'h300);
	endtask

	task automatic test_extreme_registers();
		set_geometry(31'd1, 31'h7fffffff, 31'h7fffffff);
		send_point(32'sh80000000, 32'sd5, 31'h7fffffff);
		send_point(32'sh7fffffff, -32'sd1, 31'h1);
		set_geometry(31'h7fffffff, 31'h0, 31'h7fffffff);
		send_point(32'sh80000000, 32'sh7fffffff, 31'h7fffffff);
		send_point(32'sh7fffffff, 32'sh80000000, 31'h7fffffff);
		set_geometry(31'h7fffffff, 31'h7fffffff, 31'h0);
		send_point(32'sh0, 32'sh0, 31'h7fffffff);
		send_point(32'sh7fffffff, 32'sh1, 31'h7fffffff);
	endtask

	task automatic random_points(input int count);
		logic signed [31:0] px, py;
		logic [30:0]        prad;
		longint             lo, hi, span;
		int                 p;
		lo = (longint'(vessel_len) - longint'(straight_len)) >>> 1;
		hi = (longint'(vessel_len) + longint'(straight_len)) >>> 1;
		span = (bend_r == 0) ? 64'd65536 : longint'(bend_r) * 4;
		if (span > 64'd1000000000)
			span = 64'd1000000000;
		for (int n = 0; n < count; n++) begin
			p = $urandom_range(0, 99);
			if (p < 20) begin
				px = $urandom;
				py = $urandom;
				prad = 31'($urandom);
			end else begin
				px = 32'(sat32(((p & 1) ? hi : lo) + longint'($urandom_range(0, 2000000000))
					% (2 * span + 1) - span));
				py = ($urandom_range(0, 3) == 0) ? $urandom
					: 32'(sat32(longint'($urandom_range(0, 2000000000)) % (span + 1)
					- span / 2));
				prad = ($urandom_range(0, 4) == 0) ? 31'($urandom)
					: 31'($urandom_range(0, 1 << 20));
			end
			send_point(px, py, prad);
			if (n == count / 2 && $urandom_range(0, 1))
				wait_drained();
		end
	endtask

	task automatic test_random_geometries();
		logic [30:0] r, len, str;
		for (int ph = 0; ph < 12; ph++) begin
			no_idle = (ph % 4 == 3);
			case (ph % 3)
				0: begin
					r = 31'($urandom_range(1, 64) << 16);
					len = 31'($urandom_range(50, 400) << 16);
					str = 31'($urandom_range(0, 200) << 16);
				end
				1: begin
					r = 31'($urandom);
					len = 31'($urandom);
					str = 31'($urandom);
				end
				default: begin
					r = 31'($urandom_range(1, 65536));
					len = 31'($urandom_range(0, 1 << 24));
					str = 31'($urandom_range(0, 1 << 24));
				end
			endcase
			if (ph == 5)
				r = 31'h0;
			set_geometry(r, len, str);
			random_points(130);
			no_idle = 0;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = abpt_pkg::REG_CURVATURE;
		cfg_data = '0;
		in_valid = 1'b0;
		x_in = '0;
		y_in = '0;
		radius_in = '0;
		bend_r = '0;
		vessel_len = '0;
		straight_len = '0;
		errors = 0;
		points_sent = 0;
		points_bent = 0;
		points_checked = 0;
		cycles = 0;
		no_idle = 0;
		repeat (12)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_no_bend_after_reset();
		test_directed_geometry();
		test_unused_index();
		test_extreme_registers();
		test_random_geometries();
		wait_drained();

		$display("Covered %0d points (%0d wrapped onto an arc, %0d checked) over", points_sent,
			points_bent, points_checked);
		$display("pass-through, extreme registers and random bend geometries.");
		if (errors == 0) begin
			$display("[arc_bend_point_transform] OK");
		end else begin
			$display("[arc_bend_point_transform] ERROR");
		end
		$finish;
	end

endmodule
